// ===== hdl/macs_pkg.sv =====
package macs_pkg;

   // Field widths
   localparam int PRICE_W    = 32;
   localparam int CASH_W     = 48;
   localparam int QTY_W      = 31;
   localparam int SHORT_W    = 8;
   localparam int LONG_W     = 9;
   localparam int LOT_W      = 16;
   localparam int SUM_W      = PRICE_W + LONG_W;
   localparam int PROD_W     = SUM_W + LONG_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_CNT_W  = 6;

   localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

   // Quotient bits produced by each divider pass
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_CASH = DIV_CNT_W'(CASH_W);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LOT  = DIV_CNT_W'(QTY_W);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOT_UNIT  = 2'd2;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_BUY     = 2'd1,
      ACT_SELL    = 2'd2,
      ACT_INVALID = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ_LONG,
      ST_UPDATE,
      ST_MUL_SHORT,
      ST_MUL_LONG,
      ST_DECIDE,
      ST_DIV_CASH,
      ST_SATURATE,
      ST_DIV_LOT,
      ST_FLOOR,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/macs_ram.sv =====
module macs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/moving_average_crossover_signal_core.sv =====
// Moving-average crossover signal. Each bar transfers a closing price, the cash and the
// position; each bar returns exactly one result. The last prices live in a history RAM
// with one write and one registered read port, beside running short and long sums; the
// averages are compared exactly by cross-multiplying the sums on one shared 41x9
// multiplier. The block takes one bar at a time: an invalid configuration goes straight
// to the result, a filling window ends after the sum update, and a buy at a nonzero price
// also derives the quantity on one shared restoring subtractor producing one quotient
// bit per cycle, 48 bits for cash / price and 31 bits for the lot floor.
// No clearing pass follows reset: the fill count keeps unwritten history from being used.
// Any configuration write restarts the averaging window; write only while idle.
module moving_average_crossover_signal_core #(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [macs_pkg::PRICE_W-1:0]        req_close_price,
   input  logic [macs_pkg::CASH_W-1:0]         req_cash,
   input  logic [macs_pkg::QTY_W-1:0]          req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output macs_pkg::action_type                rsp_action,
   output logic [macs_pkg::QTY_W-1:0]          rsp_quantity,
   output logic                                rsp_trend_up,
   output logic                                rsp_window_ready,
   input  logic                                csr_wr_en,
   input  logic [macs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [macs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import macs_pkg::*;

   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int BACK_W = ((IDX_W > LONG_W) ? IDX_W : LONG_W) + 1;
   localparam logic [BACK_W-1:0] DEPTH_B  = BACK_W'(HISTORY_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

   // Configuration
   logic [SHORT_W-1:0]  short_len_ff;
   logic [LONG_W-1:0]   long_len_ff;
   logic [LOT_W-1:0]    lot_unit_ff;

   // Captured bar
   logic [PRICE_W-1:0]  price_ff;
   logic [CASH_W-1:0]   cash_ff;
   logic [QTY_W-1:0]    position_ff;

   // Averaging state
   logic [SUM_W-1:0]    short_sum_ff;
   logic [SUM_W-1:0]    long_sum_ff;
   logic [LONG_W-1:0]   fill_count_ff;
   logic [LONG_W-1:0]   fill_count_in;
   logic [IDX_W-1:0]    write_index_ff;
   logic                have_prior_ff;
   logic                prior_up_ff;

   // Work registers
   logic                drop_short_ff;
   logic                drop_long_ff;
   logic [PRICE_W-1:0]  short_old_ff;
   logic [PROD_W-1:0]   prod_short_ff;
   logic [PROD_W-1:0]   prod_long_ff;
   logic [CASH_W-1:0]   dvd_ff;
   logic [PRICE_W-1:0]  rem_ff;
   logic [PRICE_W-1:0]  divisor_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [QTY_W-1:0]    qty_ff;

   // Pending result and output register
   action_type          res_action_ff;
   logic [QTY_W-1:0]    res_qty_ff;
   logic                res_up_ff;
   logic                res_ready_ff;
   logic                rsp_valid_ff;
   action_type          rsp_action_ff;
   logic [QTY_W-1:0]    rsp_qty_ff;
   logic                rsp_up_ff;
   logic                rsp_ready_ff;

   state_type           state_ff;
   state_type           state_in;

   // Control
   logic                cfg_bad;
   logic                req_xfer;
   logic                rsp_load;
   logic                div_last;
   logic                trend_up;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic                ram_wr_en;
   logic [PRICE_W-1:0]  ram_rd_data;

   // Shared datapath
   logic [SUM_W-1:0]    mul_a;
   logic [LONG_W-1:0]   mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [PRICE_W:0]    div_trial;
   logic                div_take;
   logic [PRICE_W-1:0]  div_rem_in;
   logic [QTY_W-1:0]    sat_qty;
   logic [QTY_W-1:0]    floor_qty;

   // Ring slot that lies a given number of entries behind the write index
   function automatic logic [IDX_W-1:0] slot_back(input logic [IDX_W-1:0]  wi,
                                                  input logic [LONG_W-1:0] back);
      logic [BACK_W-1:0] wi_b;
      logic [BACK_W-1:0] back_b;
      logic [BACK_W-1:0] diff;
      wi_b   = BACK_W'(wi);
      back_b = BACK_W'(back);
      if (wi_b >= back_b) begin
         diff = wi_b - back_b;
      end else begin
         diff = wi_b + DEPTH_B - back_b;
      end
      return diff[IDX_W-1:0];
   endfunction

   macs_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_index_ff),
      .wr_data (price_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration check
   assign cfg_bad = (short_len_ff == '0) ||
                    ({1'b0, short_len_ff} >= long_len_ff) ||
                    (32'(long_len_ff) > HISTORY_DEPTH) ||
                    (lot_unit_ff == '0);

   assign req_xfer = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign div_last = (div_cnt_ff == DIV_CNT_W'(1));
   assign trend_up = prod_short_ff > prod_long_ff;
   assign fill_count_in = drop_long_ff ? fill_count_ff : fill_count_ff + 1'b1;

   // Shared multiplier: short sum times long length, then long sum times short length
   assign mul_a = (state_ff == ST_MUL_SHORT) ? short_sum_ff : long_sum_ff;
   assign mul_b = (state_ff == ST_MUL_SHORT) ? long_len_ff : {1'b0, short_len_ff};
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Shared restoring divider step, one quotient bit per cycle
   assign div_trial  = {rem_ff, dvd_ff[CASH_W-1]} - {1'b0, divisor_ff};
   assign div_take   = !div_trial[PRICE_W];
   assign div_rem_in = div_take ? div_trial[PRICE_W-1:0]
                                : {rem_ff[PRICE_W-2:0], dvd_ff[CASH_W-1]};

   assign sat_qty   = (|dvd_ff[CASH_W-1:QTY_W]) ? QTY_MAX : dvd_ff[QTY_W-1:0];
   assign floor_qty = qty_ff - rem_ff[QTY_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = cfg_bad ? ST_FINISH : ST_READ_LONG;
         end
         ST_READ_LONG: state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = (fill_count_in < long_len_ff) ? ST_FINISH : ST_MUL_SHORT;
         end
         ST_MUL_SHORT: state_in = ST_MUL_LONG;
         ST_MUL_LONG:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (have_prior_ff && trend_up && !prior_up_ff && (price_ff != '0)) begin
               state_in = ST_DIV_CASH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_CASH: begin
            if (div_last) state_in = ST_SATURATE;
         end
         ST_SATURATE: state_in = ST_DIV_LOT;
         ST_DIV_LOT: begin
            if (div_last) state_in = ST_FLOOR;
         end
         ST_FLOOR: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_addr = slot_back(write_index_ff, {1'b0, short_len_ff});
      case (state_ff)
         ST_IDLE:      req_ready   = 1'b1;
         ST_READ_LONG: ram_rd_addr = slot_back(write_index_ff, long_len_ff);
         ST_UPDATE:    ram_wr_en   = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers and averaging state
   always_ff @(posedge clock) begin
      if (reset) begin
         short_len_ff    <= SHORT_W'(1);
         long_len_ff     <= LONG_W'(2);
         lot_unit_ff     <= LOT_W'(1);
         short_sum_ff    <= '0;
         long_sum_ff     <= '0;
         fill_count_ff   <= '0;
         write_index_ff  <= '0;
         have_prior_ff   <= 1'b0;
         prior_up_ff     <= 1'b0;
      end else if (csr_wr_en && (csr_index == CSR_SHORT_LEN ||
                                 csr_index == CSR_LONG_LEN ||
                                 csr_index == CSR_LOT_UNIT)) begin
         if (csr_index == CSR_SHORT_LEN) short_len_ff <= csr_wdata[SHORT_W-1:0];
         if (csr_index == CSR_LONG_LEN)  long_len_ff  <= csr_wdata[LONG_W-1:0];
         if (csr_index == CSR_LOT_UNIT)  lot_unit_ff  <= csr_wdata[LOT_W-1:0];
         short_sum_ff   <= '0;
         long_sum_ff    <= '0;
         fill_count_ff  <= '0;
         write_index_ff <= '0;
         have_prior_ff  <= 1'b0;
         prior_up_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_UPDATE: begin
               // ram_rd_data holds the price leaving the long window
               short_sum_ff  <= short_sum_ff
                              - (drop_short_ff ? SUM_W'(short_old_ff) : '0)
                              + SUM_W'(price_ff);
               long_sum_ff   <= long_sum_ff
                              - (drop_long_ff ? SUM_W'(ram_rd_data) : '0)
                              + SUM_W'(price_ff);
               fill_count_ff  <= fill_count_in;
               write_index_ff <= (write_index_ff == LAST_IDX) ? '0 : write_index_ff + 1'b1;
            end
            ST_DECIDE: begin
               have_prior_ff <= 1'b1;
               prior_up_ff   <= trend_up;
            end
            default: begin
               have_prior_ff <= have_prior_ff;
            end
         endcase
      end
   end

   // Datapath and pending result
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         price_ff    <= req_close_price;
         cash_ff     <= req_cash;
         position_ff <= req_position;
      end
      case (state_ff)
         ST_CHECK: begin
            drop_short_ff <= fill_count_ff >= {1'b0, short_len_ff};
            drop_long_ff  <= fill_count_ff >= long_len_ff;
            res_action_ff <= cfg_bad ? ACT_INVALID : ACT_NONE;
            res_qty_ff    <= '0;
            res_up_ff     <= 1'b0;
            res_ready_ff  <= 1'b0;
         end
         ST_READ_LONG: short_old_ff  <= ram_rd_data;
         ST_MUL_SHORT: prod_short_ff <= mul_p;
         ST_MUL_LONG:  prod_long_ff  <= mul_p;
         ST_DECIDE: begin
            res_up_ff    <= trend_up;
            res_ready_ff <= 1'b1;
            if (have_prior_ff && !trend_up && prior_up_ff && (position_ff != '0)) begin
               res_action_ff <= ACT_SELL;
               res_qty_ff    <= position_ff;
            end
            // Load the cash / price pass
            dvd_ff     <= cash_ff;
            divisor_ff <= price_ff;
            rem_ff     <= '0;
            div_cnt_ff <= DIV_STEPS_CASH;
         end
         ST_DIV_CASH, ST_DIV_LOT: begin
            rem_ff     <= div_rem_in;
            dvd_ff     <= {dvd_ff[CASH_W-2:0], div_take};
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         ST_SATURATE: begin
            // Load the lot pass: remainder of quantity / lot unit
            qty_ff     <= sat_qty;
            dvd_ff     <= {sat_qty, {(CASH_W-QTY_W){1'b0}}};
            divisor_ff <= PRICE_W'(lot_unit_ff);
            rem_ff     <= '0;
            div_cnt_ff <= DIV_STEPS_LOT;
         end
         ST_FLOOR: begin
            res_action_ff <= (floor_qty != '0) ? ACT_BUY : ACT_NONE;
            res_qty_ff    <= floor_qty;
         end
         default: begin
            qty_ff <= qty_ff;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_action_ff <= res_action_ff;
         rsp_qty_ff    <= res_qty_ff;
         rsp_up_ff     <= res_up_ff;
         rsp_ready_ff  <= res_ready_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_quantity     = rsp_qty_ff;
   assign rsp_trend_up     = rsp_up_ff;
   assign rsp_window_ready = rsp_ready_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= long_len_ff)
      else $error("fill count exceeds long window");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while a bar is in work");

   a_invalid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_INVALID |->
         rsp_quantity == '0 && !rsp_trend_up && !rsp_window_ready)
      else $error("invalid action carries nonzero fields");

   a_order_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_BUY || rsp_action == ACT_SELL) |->
         rsp_window_ready && rsp_quantity != '0)
      else $error("order before window full or with zero quantity");

   a_buy_trend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_BUY |-> rsp_trend_up)
      else $error("buy without rising trend");

   a_sell_trend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_SELL |-> !rsp_trend_up)
      else $error("sell with rising trend");

endmodule

// ===== sim/crossover_checker.sv =====
module crossover_checker #(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [macs_pkg::PRICE_W-1:0]        req_close_price,
   input  logic [macs_pkg::CASH_W-1:0]         req_cash,
   input  logic [macs_pkg::QTY_W-1:0]          req_position,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  macs_pkg::action_type                rsp_action,
   input  logic [macs_pkg::QTY_W-1:0]          rsp_quantity,
   input  logic                                rsp_trend_up,
   input  logic                                rsp_window_ready,
   input  logic                                csr_wr_en,
   input  logic [macs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [macs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_signals
);
   import macs_pkg::*;

   typedef struct packed {
      action_type       action;
      logic [QTY_W-1:0] quantity;
      logic             trend_up;
      logic             window_ready;
   } trade_signal_type;

   // Shadow copy of the averaging state and the registers
   logic [PRICE_W-1:0] price_ring [HISTORY_DEPTH];
   logic [63:0]        short_total;
   logic [63:0]        long_total;
   int unsigned        bars_held;
   int unsigned        ring_wr;
   bit                 trend_known;
   bit                 last_trend_up;
   logic [SHORT_W-1:0] cfg_short;
   logic [LONG_W-1:0]  cfg_long;
   logic [LOT_W-1:0]   cfg_lot;

   trade_signal_type expected_signals [$];
   int               fails = 0;

   function automatic void restart_window();
      foreach (price_ring[i]) price_ring[i] = '0;
      short_total   = '0;
      long_total    = '0;
      bars_held     = 0;
      ring_wr       = 0;
      trend_known   = 1'b0;
      last_trend_up = 1'b0;
   endfunction

   // Advance the shadow window by one bar and work out the order it causes
   function automatic trade_signal_type predict_signal(input logic [PRICE_W-1:0] price,
                                                       input logic [CASH_W-1:0]  cash,
                                                       input logic [QTY_W-1:0]   pos);
      trade_signal_type sig;
      logic             up;
      logic [63:0]      buy_qty;
      sig = '0;
      if (cfg_short == 0 || cfg_short >= cfg_long || cfg_long > HISTORY_DEPTH ||
          cfg_lot == 0) begin
         // bad settings: flag it, bar leaves no trace
         sig.action = ACT_INVALID;
         return sig;
      end
      if (bars_held >= cfg_short)
         short_total -= price_ring[(ring_wr + HISTORY_DEPTH - cfg_short) % HISTORY_DEPTH];
      if (bars_held >= cfg_long)
         long_total -= price_ring[(ring_wr + HISTORY_DEPTH - cfg_long) % HISTORY_DEPTH];
      else
         bars_held++;
      short_total += price;
      long_total  += price;
      price_ring[ring_wr] = price;
      ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
      if (bars_held < cfg_long)
         return sig;

      sig.window_ready = 1'b1;
      // exact compare of the averages by cross-multiplying the sums
      up = (short_total * cfg_long) > (long_total * cfg_short);
      sig.trend_up = up;
      if (!trend_known) begin
         trend_known   = 1'b1;
         last_trend_up = up;
         return sig;
      end
      if (up && !last_trend_up && price != 0) begin
         buy_qty = cash / price;
         if (buy_qty > QTY_MAX)
            buy_qty = QTY_MAX;
         buy_qty = buy_qty / cfg_lot * cfg_lot;
         if (buy_qty != 0) begin
            sig.action   = ACT_BUY;
            sig.quantity = buy_qty[QTY_W-1:0];
         end
      end else if (!up && last_trend_up && pos != 0) begin
         sig.action   = ACT_SELL;
         sig.quantity = pos;
      end
      last_trend_up = up;
      return sig;
   endfunction

   // Watch all three ports at each edge
   always @(posedge clock) begin : watch
      trade_signal_type want;
      if (reset) begin
         cfg_short = SHORT_W'(1);
         cfg_long  = LONG_W'(2);
         cfg_lot   = LOT_W'(1);
         restart_window();
         expected_signals.delete();
      end else begin
         // result transfer: check against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_signals.size() == 0) begin
               if (fails < 10)
                  $display("%0t: result with nothing expected: action %0d qty %0d",
                           $time, rsp_action, rsp_quantity);
               fails++;
            end else begin
               want = expected_signals[0];
               expected_signals.delete(0);
               if (rsp_action != want.action || rsp_quantity != want.quantity ||
                   rsp_trend_up != want.trend_up ||
                   rsp_window_ready != want.window_ready) begin
                  if (fails < 10) begin
                     $display("%0t: mismatch: expected action %0d qty %0d up %0b ready %0b",
                              $time, want.action, want.quantity, want.trend_up,
                              want.window_ready);
                     $display("%0t:           got action %0d qty %0d up %0b ready %0b",
                              $time, rsp_action, rsp_quantity, rsp_trend_up,
                              rsp_window_ready);
                  end
                  fails++;
               end
            end
         end
         // register write; any mapped register restarts the window
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SHORT_LEN: begin
                  cfg_short = csr_wdata[SHORT_W-1:0];
                  restart_window();
               end
               CSR_LONG_LEN: begin
                  cfg_long = csr_wdata[LONG_W-1:0];
                  restart_window();
               end
               CSR_LOT_UNIT: begin
                  cfg_lot = csr_wdata[LOT_W-1:0];
                  restart_window();
               end
               default: ;
            endcase
         end
         // bar transfer
         if (req_valid && req_ready)
            expected_signals.insert(expected_signals.size(),
                                    predict_signal(req_close_price, req_cash,
                                                   req_position));
      end
      mismatch_count  <= fails;
      pending_signals <= expected_signals.size();
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import macs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int BAR_TARGET = 1800;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [PRICE_W-1:0] req_close_price;
   logic [CASH_W-1:0] req_cash;
   logic [QTY_W-1:0] req_position;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   action_type rsp_action;
   logic [QTY_W-1:0] rsp_quantity;
   logic rsp_trend_up;
   logic rsp_window_ready;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_signals;
   bit steady_flow;
   int bars_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   moving_average_crossover_signal_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_close_price  (req_close_price),
      .req_cash         (req_cash),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_quantity     (rsp_quantity),
      .rsp_trend_up     (rsp_trend_up),
      .rsp_window_ready (rsp_window_ready),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   crossover_checker signal_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_close_price  (req_close_price),
      .req_cash         (req_cash),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_quantity     (rsp_quantity),
      .rsp_trend_up     (rsp_trend_up),
      .rsp_window_ready (rsp_window_ready),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pending_signals  (pending_signals)
   );

   // Result side back-pressure
   always @(posedge clock) begin
      if (steady_flow)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 20);
   end

   // One bar transfer, with an occasional idle gap in front
   task automatic send_bar(input logic [PRICE_W-1:0] price, input logic [CASH_W-1:0] cash,
                           input logic [QTY_W-1:0] pos);
      int gap;
      gap = 0;
      if (!steady_flow && $urandom_range(99) < 20)
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_close_price <= price;
      req_cash        <= cash;
      req_position    <= pos;
      do @(posedge clock); while (!req_ready);
      bars_sent++;
   endtask

   // Wait until every bar sent has been answered
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_signals != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // All three registers in a random order; spare data bits carry noise
   task automatic set_windows(input int s, input int l, input int lot);
      int first;
      first = $urandom_range(2);
      for (int k = 0; k < 3; k++) begin
         case ((first + k) % 3)
            0: csr_write(CSR_SHORT_LEN, {8'($urandom_range(255)), 8'(s)});
            1: csr_write(CSR_LONG_LEN, {7'($urandom), 9'(l)});
            default: csr_write(CSR_LOT_UNIT, 16'(lot));
         endcase
      end
   endtask

   // One setting, then a run of bars: a random walk or scattered prices
   task automatic run_phase(input int s, input int l, input int lot, input int bars);
      logic [PRICE_W-1:0] price;
      logic [CASH_W-1:0] cash;
      logic [QTY_W-1:0] pos;
      longint unsigned walk;
      longint unsigned delta;
      int style;
      set_windows(s, l, lot);
      if ($urandom_range(4) == 0)
         csr_write(CSR_UNMAPPED, 16'($urandom));
      style = $urandom_range(1);
      walk = $urandom >> $urandom_range(0, 28);
      for (int n = 0; n < bars; n++) begin
         steady_flow <= (bars_sent >= 900 && bars_sent < 1200);
         if (style == 0) begin
            delta = $urandom_range(0, 32'((walk >> 3) + 1));
            if ($urandom_range(1))
               walk = (walk + delta > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : walk + delta;
            else
               walk = (walk > delta) ? walk - delta : 64'd0;
            price = walk[PRICE_W-1:0];
         end else begin
            price = $urandom >> $urandom_range(0, 31);
         end
         if ($urandom_range(24) == 0)
            price = '0;
         case ($urandom_range(2))
            0: cash = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
            1: cash = 48'(price * 64'($urandom_range(0, 5000)) + $urandom_range(0, 999));
            default: cash = 48'($urandom_range(0, 32'(price)));
         endcase
         pos = ($urandom_range(7) == 0) ? '0 : 31'($urandom >> $urandom_range(1, 31));
         send_bar(price, cash, pos);
      end
      drain();
   endtask

   initial begin : stimulus
      int kind;
      int s;
      int l;
      int lot;
      int bars;
      req_valid       <= 1'b0;
      req_close_price <= '0;
      req_cash        <= '0;
      req_position    <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      steady_flow     <= 1'b0;
      reset           <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset windows (1 of 2): a rising close buys, a falling close sells
      send_bar(32'd100, 48'd5000, 31'd7);     // window still filling
      send_bar(32'd50, 48'd5000, 31'd7);      // first full bar records the trend only
      send_bar('1, '1, '1);                   // rise at top price with all cash
      send_bar(32'd1, '1, QTY_MAX);           // fall: sell the largest position
      send_bar(32'd2, '1, '0);                // rise: quotient saturates
      send_bar(32'd1, '0, '0);                // fall with no shares: no order
      send_bar(32'd3, 48'd2, 31'd5);          // rise, cash below price: nothing to buy
      send_bar(32'd4, 48'd1000, 31'd5);       // still rising: no new order
      drain();
      // out-of-range index must leave the window alone
      csr_write(CSR_UNMAPPED, '1);
      send_bar(32'd1, 48'd100, 31'd9);
      drain();

      // 2 of 3 with lots of 1000: zero-price rise, then a sell and a floored buy
      set_windows(2, 3, 1000);
      send_bar(32'd100, 48'd500, 31'd3);
      send_bar(32'd0, 48'd500, 31'd3);
      send_bar(32'd50, 48'd500, 31'd3);
      send_bar(32'd0, '1, 31'd3);
      send_bar(32'd0, 48'd500, 31'd3);
      send_bar(32'd7000, 48'd12_345_678, 31'd3);
      drain();

      // bad settings: zero short, short not below long, long too deep, zero lot
      set_windows(0, 3, 1);
      send_bar(32'd10, 48'd10, 31'd1);
      drain();
      set_windows(4, 4, 1);
      send_bar(32'd10, 48'd10, 31'd1);
      drain();
      set_windows(1, 257, 1);
      send_bar(32'd10, 48'd10, 31'd1);
      drain();
      set_windows(1, 2, 0);
      send_bar(32'd10, 48'd10, 31'd1);
      drain();

      // widest windows and largest lot, then the longest window alone
      run_phase(255, 256, 65535, 300);
      run_phase(1, 256, 1, 280);

      while (bars_sent < BAR_TARGET) begin
         kind = $urandom_range(99);
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: lot = 1;
            6, 7: lot = $urandom_range(2, 100);
            8: lot = $urandom_range(1, 65535);
            default: lot = 65535;
         endcase
         if (kind < 6) begin
            bars = $urandom_range(1, 4);
            case ($urandom_range(3))
               0: begin
                  s = 0;
                  l = $urandom_range(2, 20);
               end
               1: begin
                  s = $urandom_range(2, 255);
                  l = $urandom_range(0, s);
               end
               2: begin
                  s = $urandom_range(1, 255);
                  l = $urandom_range(257, 511);
               end
               default: begin
                  l = $urandom_range(2, 12);
                  s = $urandom_range(1, l - 1);
                  lot = 0;
               end
            endcase
         end else if (kind < 12) begin
            l = $urandom_range(100, 256);
            s = $urandom_range(1, l - 1);
            bars = l + $urandom_range(20, 60);
         end else begin
            l = $urandom_range(2, 12);
            s = $urandom_range(1, l - 1);
            bars = l + $urandom_range(10, 60);
         end
         run_phase(s, l, lot, bars);
      end

      // trailing window for any stray result
      drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_signals == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Hang guard
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== moving_average_crossover_signal_core.f =====
hdl/macs_pkg.sv
hdl/macs_ram.sv
hdl/moving_average_crossover_signal_core.sv
sim/crossover_checker.sv
sim/tb_top.sv
